// File: sv/hmr_pkg.sv
`default_nettype none
package hmr_pkg;

  localparam int VW       = 48;
  localparam int LOG      = 16;
  localparam int SPAN     = 1 << LOG;
  localparam int NODE_AW  = LOG + 1;
  localparam int TAG_AW   = LOG;
  localparam int POS_W    = LOG + 2;
  localparam int HI_W     = LOG + 1;
  localparam int LVL_W    = 5;
  localparam int KIND_W   = 3;
  localparam int NODE_W   = 2 * VW;
  localparam int TAG_W    = 4 * VW;

  localparam logic [HI_W-1:0]   LIM_MAX   = HI_W'(SPAN);
  localparam logic [HI_W-1:0]   EIU_RESET = HI_W'(SPAN);
  localparam logic [POS_W-1:0]  POS_BASE  = POS_W'(SPAN);

  localparam logic signed [VW-1:0] NEG    = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] MAXV   = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] NEG_P1 = {1'b1, {(VW-2){1'b0}}, 1'b1};

  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RAISE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QMAX   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QHIST  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd5;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DN_SEL, ST_PU_TAG, ST_PU_CHK, ST_AP_RD, ST_AP_SUM,
    ST_AP_WR, ST_PU_CLR, ST_MID_SEL, ST_Q_RD, ST_Q_ACC, ST_LEAF, ST_UP_SEL,
    ST_PL_RD0, ST_PL_RD1, ST_PL_WR, ST_DONE
  } state_t;

  typedef enum logic [1:0] {CTX_PUSH0, CTX_PUSH1, CTX_CANON} ctx_t;

  typedef enum logic [1:0] {NW_CLEAR, NW_APPLY, NW_PULL, NW_LEAF} nwsel_t;

  typedef enum logic {TW_IDENT, TW_APPLY} twsel_t;

  typedef struct packed {
    logic               accept;
    logic [NODE_AW-1:0] node_raddr;
    logic               node_we;
    logic [NODE_AW-1:0] node_waddr;
    nwsel_t             node_wsel;
    logic [TAG_AW-1:0]  tag_raddr;
    logic               tag_we;
    logic [TAG_AW-1:0]  tag_waddr;
    twsel_t             tag_wsel;
    logic               ops_tag;
    logic               ops_item;
    logic               sum_en;
    logic               pl_first;
    logic               acc_en;
  } cmd_t;

  function automatic logic signed [VW-1:0] smax(input logic signed [VW-1:0] x,
                                                input logic signed [VW-1:0] y);
    return (x > y) ? x : y;
  endfunction

  // Saturating add; negative infinity absorbs.
  function automatic logic signed [VW-1:0] sadd(input logic signed [VW-1:0] x,
                                                input logic signed [VW-1:0] y);
    logic [VW:0] s;
    s = {x[VW-1], x} + {y[VW-1], y};
    if (x == NEG || y == NEG) return NEG;
    if (!s[VW] && s[VW-1]) return MAXV;
    if (s[VW] && !s[VW-1]) return NEG_P1;
    if (s[VW-1:0] == NEG) return NEG_P1;
    return s[VW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/historic_max_range_tree_core.sv
// An ignored word leaves the block idle for the next cycle, a query over an empty range is
// answered in the cycle after it is taken, and a range word is worked through a walk of the tree.
// A query result is strobed on out_valid in the cycle after its walk ends. One word is worked
// at a time, so throughput is one word per walk, set by visiting memory nodes one at a time per
// level. After reset a clearing pass over every node and tag word holds busy high; configuration
// is still taken. The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module historic_max_range_tree_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [hmr_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [15:0]                   in_lo,
  input  wire logic [hmr_pkg::HI_W-1:0]      in_hi,
  input  wire logic signed [hmr_pkg::VW-1:0] in_value,
  output logic                               out_valid,
  output logic signed [hmr_pkg::VW-1:0]      out_result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [hmr_pkg::HI_W-1:0]      cfg_elements_in_use
);

  hmr_pkg::cmd_t cmd;
  logic          tag_ident;

  hmr_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .in_kind             (in_kind),
    .in_lo               (in_lo),
    .in_hi               (in_hi),
    .cfg_valid           (cfg_valid),
    .cfg_elements_in_use (cfg_elements_in_use),
    .tag_ident           (tag_ident),
    .cfg_ready           (cfg_ready),
    .busy                (busy),
    .out_valid           (out_valid),
    .cmd                 (cmd)
  );

  hmr_dp u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .in_kind    (in_kind),
    .in_value   (in_value),
    .tag_ident  (tag_ident),
    .out_result (out_result)
  );

endmodule
`default_nettype wire

// File: sv/hmr_ram.sv
`default_nettype none
module hmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/hmr_ctrl.sv
`default_nettype none
module hmr_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [hmr_pkg::KIND_W-1:0] in_kind,
  input  wire logic [15:0]                in_lo,
  input  wire logic [hmr_pkg::HI_W-1:0]   in_hi,
  input  wire logic                       cfg_valid,
  input  wire logic [hmr_pkg::HI_W-1:0]   cfg_elements_in_use,
  input  wire logic                       tag_ident,
  output logic                            cfg_ready,
  output logic                            busy,
  output logic                            out_valid,
  output hmr_pkg::cmd_t                   cmd
);

  hmr_pkg::state_t state_r, state_nxt;
  hmr_pkg::ctx_t   ctx_r, ctx_nxt;
  logic [hmr_pkg::NODE_AW-1:0] clr_r, clr_nxt;
  logic [hmr_pkg::HI_W-1:0]    eiu_r;
  logic [hmr_pkg::KIND_W-1:0]  kind_r, kind_nxt;
  logic [hmr_pkg::LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [1:0]                  side_r, side_nxt;
  logic [hmr_pkg::POS_W-1:0]   L_r, L_nxt, R_r, R_nxt, l_r, l_nxt, r_r, r_nxt;
  logic [hmr_pkg::TAG_AW-1:0]  k_r, k_nxt;
  logic [hmr_pkg::NODE_AW-1:0] c_r, c_nxt;

  logic [hmr_pkg::HI_W-1:0]  lim, hic;
  logic [hmr_pkg::POS_W-1:0] pos_l, pos_r, mask, kpos, rm1, rdec;
  logic                      need, is_query;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hmr_pkg::ST_CLEAR;
      clr_r   <= '0;
      eiu_r   <= hmr_pkg::EIU_RESET;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (cfg_valid) begin
        eiu_r <= cfg_elements_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    ctx_r  <= ctx_nxt;
    kind_r <= kind_nxt;
    lvl_r  <= lvl_nxt;
    side_r <= side_nxt;
    L_r    <= L_nxt;
    R_r    <= R_nxt;
    l_r    <= l_nxt;
    r_r    <= r_nxt;
    k_r    <= k_nxt;
    c_r    <= c_nxt;
  end

  assign lim      = (eiu_r > hmr_pkg::LIM_MAX) ? hmr_pkg::LIM_MAX : eiu_r;
  assign hic      = (in_hi > lim) ? lim : in_hi;
  assign pos_l    = {2'b01, in_lo};
  assign pos_r    = {1'b0, hic} + hmr_pkg::POS_BASE;
  assign mask     = (hmr_pkg::POS_W'(1) << lvl_r) - hmr_pkg::POS_W'(1);
  assign rm1      = R_r - hmr_pkg::POS_W'(1);
  assign rdec     = r_r - hmr_pkg::POS_W'(1);
  assign need     = (side_r == 2'd0) ? |(L_r & mask) : |(R_r & mask);
  assign kpos     = (side_r == 2'd0) ? (L_r >> lvl_r) : (rm1 >> lvl_r);
  assign is_query = kind_r inside {hmr_pkg::KIND_QMAX, hmr_pkg::KIND_QHIST};

  always_comb begin
    state_nxt = state_r;
    ctx_nxt   = ctx_r;
    clr_nxt   = clr_r;
    kind_nxt  = kind_r;
    lvl_nxt   = lvl_r;
    side_nxt  = side_r;
    L_nxt     = L_r;
    R_nxt     = R_r;
    l_nxt     = l_r;
    r_nxt     = r_r;
    k_nxt     = k_r;
    c_nxt     = c_r;
    case (state_r)
      hmr_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) state_nxt = hmr_pkg::ST_IDLE;
      end
      hmr_pkg::ST_IDLE: begin
        if (start) begin
          kind_nxt = in_kind;
          L_nxt    = pos_l;
          R_nxt    = pos_r;
          lvl_nxt  = hmr_pkg::LVL_W'(hmr_pkg::LOG);
          side_nxt = 2'd0;
          if (in_kind == hmr_pkg::KIND_LOAD) begin
            R_nxt = pos_l + hmr_pkg::POS_W'(1);
            if ({1'b0, in_lo} < lim) state_nxt = hmr_pkg::ST_DN_SEL;
          end else if (in_kind inside {hmr_pkg::KIND_ADD, hmr_pkg::KIND_ASSIGN,
                                       hmr_pkg::KIND_RAISE}) begin
            if ({1'b0, in_lo} < hic) state_nxt = hmr_pkg::ST_DN_SEL;
          end else if (in_kind inside {hmr_pkg::KIND_QMAX, hmr_pkg::KIND_QHIST}) begin
            state_nxt = ({1'b0, in_lo} < hic) ? hmr_pkg::ST_DN_SEL : hmr_pkg::ST_DONE;
          end
        end
      end
      hmr_pkg::ST_DN_SEL: begin
        if (lvl_r == '0) begin
          if (kind_r == hmr_pkg::KIND_LOAD) begin
            state_nxt = hmr_pkg::ST_LEAF;
          end else begin
            state_nxt = hmr_pkg::ST_MID_SEL;
            l_nxt     = L_r;
            r_nxt     = R_r;
            side_nxt  = 2'd0;
          end
        end else begin
          k_nxt = kpos[hmr_pkg::TAG_AW-1:0];
          if (side_r == 2'd0) begin
            side_nxt = 2'd1;
          end else begin
            side_nxt = 2'd0;
            lvl_nxt  = lvl_r - 1'b1;
          end
          if (need) state_nxt = hmr_pkg::ST_PU_TAG;
        end
      end
      hmr_pkg::ST_PU_TAG: state_nxt = hmr_pkg::ST_PU_CHK;
      hmr_pkg::ST_PU_CHK: begin
        if (tag_ident) begin
          state_nxt = hmr_pkg::ST_DN_SEL;
        end else begin
          state_nxt = hmr_pkg::ST_AP_RD;
          c_nxt     = {k_r, 1'b0};
          ctx_nxt   = hmr_pkg::CTX_PUSH0;
        end
      end
      hmr_pkg::ST_AP_RD:  state_nxt = hmr_pkg::ST_AP_SUM;
      hmr_pkg::ST_AP_SUM: state_nxt = hmr_pkg::ST_AP_WR;
      hmr_pkg::ST_AP_WR: begin
        case (ctx_r)
          hmr_pkg::CTX_PUSH0: begin
            state_nxt = hmr_pkg::ST_AP_RD;
            c_nxt     = {k_r, 1'b1};
            ctx_nxt   = hmr_pkg::CTX_PUSH1;
          end
          hmr_pkg::CTX_PUSH1: state_nxt = hmr_pkg::ST_PU_CLR;
          default:            state_nxt = hmr_pkg::ST_MID_SEL;
        endcase
      end
      hmr_pkg::ST_PU_CLR: state_nxt = hmr_pkg::ST_DN_SEL;
      hmr_pkg::ST_MID_SEL: begin
        ctx_nxt = hmr_pkg::CTX_CANON;
        case (side_r)
          2'd0: begin
            if (l_r >= r_r) begin
              if (is_query) begin
                state_nxt = hmr_pkg::ST_DONE;
              end else begin
                state_nxt = hmr_pkg::ST_UP_SEL;
                lvl_nxt   = hmr_pkg::LVL_W'(1);
              end
            end else begin
              side_nxt = 2'd1;
              if (l_r[0]) begin
                c_nxt     = l_r[hmr_pkg::NODE_AW-1:0];
                l_nxt     = l_r + hmr_pkg::POS_W'(1);
                state_nxt = is_query ? hmr_pkg::ST_Q_RD : hmr_pkg::ST_AP_RD;
              end
            end
          end
          2'd1: begin
            side_nxt = 2'd2;
            if (r_r[0]) begin
              c_nxt     = rdec[hmr_pkg::NODE_AW-1:0];
              r_nxt     = rdec;
              state_nxt = is_query ? hmr_pkg::ST_Q_RD : hmr_pkg::ST_AP_RD;
            end
          end
          default: begin
            side_nxt = 2'd0;
            l_nxt    = l_r >> 1;
            r_nxt    = r_r >> 1;
          end
        endcase
      end
      hmr_pkg::ST_Q_RD:  state_nxt = hmr_pkg::ST_Q_ACC;
      hmr_pkg::ST_Q_ACC: state_nxt = hmr_pkg::ST_MID_SEL;
      hmr_pkg::ST_LEAF: begin
        state_nxt = hmr_pkg::ST_UP_SEL;
        lvl_nxt   = hmr_pkg::LVL_W'(1);
        side_nxt  = 2'd0;
      end
      hmr_pkg::ST_UP_SEL: begin
        if (lvl_r == hmr_pkg::LVL_W'(hmr_pkg::LOG + 1)) begin
          state_nxt = hmr_pkg::ST_IDLE;
        end else begin
          k_nxt = kpos[hmr_pkg::TAG_AW-1:0];
          if (side_r == 2'd0) begin
            side_nxt = 2'd1;
          end else begin
            side_nxt = 2'd0;
            lvl_nxt  = lvl_r + 1'b1;
          end
          if (need) state_nxt = hmr_pkg::ST_PL_RD0;
        end
      end
      hmr_pkg::ST_PL_RD0: state_nxt = hmr_pkg::ST_PL_RD1;
      hmr_pkg::ST_PL_RD1: state_nxt = hmr_pkg::ST_PL_WR;
      hmr_pkg::ST_PL_WR:  state_nxt = hmr_pkg::ST_UP_SEL;
      hmr_pkg::ST_DONE:   state_nxt = hmr_pkg::ST_IDLE;
      default:            state_nxt = hmr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.node_wsel  = hmr_pkg::NW_CLEAR;
    cmd.tag_wsel   = hmr_pkg::TW_IDENT;
    busy           = (state_r != hmr_pkg::ST_IDLE);
    out_valid      = 1'b0;
    cfg_ready      = 1'b1;
    case (state_r)
      hmr_pkg::ST_CLEAR: begin
        cmd.node_we    = 1'b1;
        cmd.node_waddr = clr_r;
        cmd.tag_we     = ~clr_r[hmr_pkg::NODE_AW-1];
        cmd.tag_waddr  = clr_r[hmr_pkg::TAG_AW-1:0];
      end
      hmr_pkg::ST_IDLE:   cmd.accept = start;
      hmr_pkg::ST_PU_TAG: cmd.tag_raddr = k_r;
      hmr_pkg::ST_PU_CHK: cmd.ops_tag = 1'b1;
      hmr_pkg::ST_AP_RD: begin
        cmd.node_raddr = c_r;
        cmd.tag_raddr  = c_r[hmr_pkg::TAG_AW-1:0];
      end
      hmr_pkg::ST_AP_SUM: cmd.sum_en = 1'b1;
      hmr_pkg::ST_AP_WR: begin
        cmd.node_we    = 1'b1;
        cmd.node_waddr = c_r;
        cmd.node_wsel  = hmr_pkg::NW_APPLY;
        cmd.tag_we     = ~c_r[hmr_pkg::NODE_AW-1];
        cmd.tag_waddr  = c_r[hmr_pkg::TAG_AW-1:0];
        cmd.tag_wsel   = hmr_pkg::TW_APPLY;
      end
      hmr_pkg::ST_PU_CLR: begin
        cmd.tag_we    = 1'b1;
        cmd.tag_waddr = k_r;
      end
      hmr_pkg::ST_MID_SEL: cmd.ops_item = 1'b1;
      hmr_pkg::ST_Q_RD:    cmd.node_raddr = c_r;
      hmr_pkg::ST_Q_ACC:   cmd.acc_en = 1'b1;
      hmr_pkg::ST_LEAF: begin
        cmd.node_we    = 1'b1;
        cmd.node_waddr = L_r[hmr_pkg::NODE_AW-1:0];
        cmd.node_wsel  = hmr_pkg::NW_LEAF;
      end
      hmr_pkg::ST_PL_RD0: cmd.node_raddr = {k_r, 1'b0};
      hmr_pkg::ST_PL_RD1: begin
        cmd.node_raddr = {k_r, 1'b1};
        cmd.pl_first   = 1'b1;
      end
      hmr_pkg::ST_PL_WR: begin
        cmd.node_we    = 1'b1;
        cmd.node_waddr = {1'b0, k_r};
        cmd.node_wsel  = hmr_pkg::NW_PULL;
      end
      hmr_pkg::ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/hmr_dp.sv
`default_nettype none
module hmr_dp (
  input  wire logic                          clk,
  input  wire hmr_pkg::cmd_t                 cmd,
  input  wire logic [hmr_pkg::KIND_W-1:0]    in_kind,
  input  wire logic signed [hmr_pkg::VW-1:0] in_value,
  output logic                               tag_ident,
  output logic signed [hmr_pkg::VW-1:0]      out_result
);

  logic [hmr_pkg::NODE_W-1:0] node_rdata, node_wdata;
  logic [hmr_pkg::TAG_W-1:0]  tag_rdata, tag_wdata;
  logic signed [hmr_pkg::VW-1:0] rd_m, rd_h, rd_ta, rd_tb, rd_tha, rd_thb;
  logic signed [hmr_pkg::VW-1:0] it_a, it_b;

  logic signed [hmr_pkg::VW-1:0] it_a_r, it_b_r, acc_r;
  logic                          qhist_r;
  logic signed [hmr_pkg::VW-1:0] op_a_r, op_b_r, op_ha_r, op_hb_r;
  logic signed [hmr_pkg::VW-1:0] s_ma_r, s_mha_r, h_r, s_oaa_r;
  logic signed [hmr_pkg::VW-1:0] s_oba_r, s_oaha_r, s_obha_r;
  logic signed [hmr_pkg::VW-1:0] ohadd_r, ohfloor_r, pl_m_r, pl_h_r;

  hmr_ram #(.WIDTH(hmr_pkg::NODE_W), .DEPTH(2 * hmr_pkg::SPAN)) u_node_ram (
    .clk   (clk),
    .we    (cmd.node_we),
    .waddr (cmd.node_waddr),
    .wdata (node_wdata),
    .raddr (cmd.node_raddr),
    .rdata (node_rdata)
  );

  hmr_ram #(.WIDTH(hmr_pkg::TAG_W), .DEPTH(hmr_pkg::SPAN)) u_tag_ram (
    .clk   (clk),
    .we    (cmd.tag_we),
    .waddr (cmd.tag_waddr),
    .wdata (tag_wdata),
    .raddr (cmd.tag_raddr),
    .rdata (tag_rdata)
  );

  assign {rd_m, rd_h}                 = node_rdata;
  assign {rd_ta, rd_tb, rd_tha, rd_thb} = tag_rdata;
  assign tag_ident = (rd_ta == '0) && (rd_tha == '0) &&
                     (rd_tb == hmr_pkg::NEG) && (rd_thb == hmr_pkg::NEG);

  always_comb begin
    it_a = '0;
    it_b = in_value;
    case (in_kind)
      hmr_pkg::KIND_ADD: begin
        it_a = (in_value == hmr_pkg::NEG) ? hmr_pkg::NEG_P1 : in_value;
        it_b = hmr_pkg::NEG;
      end
      hmr_pkg::KIND_ASSIGN: it_a = hmr_pkg::NEG;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      it_a_r  <= it_a;
      it_b_r  <= it_b;
      qhist_r <= (in_kind == hmr_pkg::KIND_QHIST);
      acc_r   <= hmr_pkg::NEG;
    end else if (cmd.acc_en) begin
      acc_r <= hmr_pkg::smax(acc_r, qhist_r ? rd_h : rd_m);
    end
    if (cmd.ops_tag) begin
      op_a_r  <= rd_ta;
      op_b_r  <= rd_tb;
      op_ha_r <= rd_tha;
      op_hb_r <= rd_thb;
    end else if (cmd.ops_item) begin
      op_a_r  <= it_a_r;
      op_b_r  <= it_b_r;
      op_ha_r <= it_a_r;
      op_hb_r <= it_b_r;
    end
    if (cmd.sum_en) begin
      s_ma_r    <= hmr_pkg::sadd(rd_m, op_a_r);
      s_mha_r   <= hmr_pkg::sadd(rd_m, op_ha_r);
      h_r       <= rd_h;
      s_oaa_r   <= hmr_pkg::sadd(rd_ta, op_a_r);
      s_oba_r   <= hmr_pkg::sadd(rd_tb, op_a_r);
      s_oaha_r  <= hmr_pkg::sadd(rd_ta, op_ha_r);
      s_obha_r  <= hmr_pkg::sadd(rd_tb, op_ha_r);
      ohadd_r   <= rd_tha;
      ohfloor_r <= rd_thb;
    end
    if (cmd.pl_first) begin
      pl_m_r <= rd_m;
      pl_h_r <= rd_h;
    end
  end

  always_comb begin
    case (cmd.node_wsel)
      hmr_pkg::NW_APPLY: node_wdata = {hmr_pkg::smax(s_ma_r, op_b_r),
                                       hmr_pkg::smax(h_r, hmr_pkg::smax(s_mha_r, op_hb_r))};
      hmr_pkg::NW_PULL:  node_wdata = {hmr_pkg::smax(pl_m_r, rd_m),
                                       hmr_pkg::smax(pl_h_r, rd_h)};
      hmr_pkg::NW_LEAF:  node_wdata = {it_b_r, it_b_r};
      default:           node_wdata = {hmr_pkg::NEG, hmr_pkg::NEG};
    endcase
  end

  always_comb begin
    case (cmd.tag_wsel)
      hmr_pkg::TW_APPLY: tag_wdata = {s_oaa_r,
                                      hmr_pkg::smax(s_oba_r, op_b_r),
                                      hmr_pkg::smax(ohadd_r, s_oaha_r),
                                      hmr_pkg::smax(hmr_pkg::smax(ohfloor_r, s_obha_r),
                                                    op_hb_r)};
      default:           tag_wdata = {{hmr_pkg::VW{1'b0}}, hmr_pkg::NEG,
                                      {hmr_pkg::VW{1'b0}}, hmr_pkg::NEG};
    endcase
  end

  assign out_result = acc_r;

endmodule
`default_nettype wire
